[rtl/pmpf_pkg.sv]
package pmpf_pkg;

  localparam int NUM_COORDS        = 4;
  localparam int MAX_POINTS_DEF    = 32;
  localparam int COORD_WIDTH_DEF   = 16;
  localparam int DIMS_W            = 3;
  localparam int ADDR_W            = 2;
  localparam int DATA_W            = 32;

  localparam logic [DIMS_W-1:0] DIMS_RESET    = 3'd4;
  localparam logic [ADDR_W-1:0] REG_DIMS_USED = 2'd0;

  typedef struct packed {
    logic                  upd;
    logic                  shift;
    logic                  clear;
    logic [NUM_COORDS-1:0] dim_mask;
  } lane_ctl_t;

  typedef struct packed {
    logic self_drop;
    logic any_kept;
    logic head_kept;
    logic head_last;
  } merge_t;

  // dims 0 acts as 1, above 4 acts as 4
  function automatic logic [NUM_COORDS-1:0] dims_mask(input logic [DIMS_W-1:0] dims);
    logic [NUM_COORDS-1:0] m;
    m[0] = 1'b1;
    m[1] = (dims >= 3'd2);
    m[2] = (dims >= 3'd3);
    m[3] = (dims >= 3'd4);
    return m;
  endfunction

endpackage

[rtl/pareto_minimal_point_filter.sv]
// the first result follows the last point through the emission state and the result register;
//   each dropped point stored ahead of the oldest survivor is shifted out first
// throughput: one point per cycle while loading with busy low; emission then shifts
//   the lanes one place per cycle with busy high, one result at most per cycle
// each result is on the ports for one cycle only; the receiver cannot stall
// reset: synchronous active-low rst_n empties the store, clears the batch, dims_used = 4
module pareto_minimal_point_filter #(
  parameter int MAX_POINTS  = pmpf_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH = pmpf_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pmpf_pkg::ADDR_W-1:0]       paddr,
  input  logic [pmpf_pkg::DATA_W-1:0]       pwdata,
  output logic [pmpf_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  input  logic                              start,
  output logic                              busy,
  input  logic [COORD_WIDTH-1:0]            in_coord_0,
  input  logic [COORD_WIDTH-1:0]            in_coord_1,
  input  logic [COORD_WIDTH-1:0]            in_coord_2,
  input  logic [COORD_WIDTH-1:0]            in_coord_3,
  input  logic                              in_last_point,
  output logic                              out_strobe,
  output logic [COORD_WIDTH-1:0]            out_coord_0,
  output logic [COORD_WIDTH-1:0]            out_coord_1,
  output logic [COORD_WIDTH-1:0]            out_coord_2,
  output logic [COORD_WIDTH-1:0]            out_coord_3,
  output logic                              out_last_kept,
  output logic                              out_none_kept,
  output logic                              out_overflowed
);
  import pmpf_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [DIMS_W-1:0]       dims_r;
  logic                    out_strobe_r, out_strobe_nxt;
  logic                    res_last, res_none;
  logic                    accept, full, cfg_wr;
  lane_ctl_t               ctl;
  merge_t                  mrg;

  logic [NUM_COORDS-1:0][COORD_WIDTH-1:0] new_pt;
  logic [MAX_POINTS:0][NUM_COORDS-1:0][COORD_WIDTH-1:0] lane_pt;
  logic [MAX_POINTS:0]     lane_occ;
  logic [MAX_POINTS:0]     lane_drop;
  logic [MAX_POINTS-1:0]   lane_hit;

  logic [NUM_COORDS-1:0][COORD_WIDTH-1:0] out_pt_r;
  logic                    out_last_r, out_none_r, out_ovf_r;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr == REG_DIMS_USED) ? {{(DATA_W-DIMS_W){1'b0}}, dims_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= DIMS_RESET;
    end else if (cfg_wr && (paddr == REG_DIMS_USED)) begin
      dims_r <= pwdata[DIMS_W-1:0];
    end
  end

  assign new_pt[0] = in_coord_0;
  assign new_pt[1] = in_coord_1;
  assign new_pt[2] = in_coord_2;
  assign new_pt[3] = in_coord_3;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start & ~busy;
  assign full   = (count_r == CNT_W'(MAX_POINTS));

  // top neighbor of the last lane is empty
  assign lane_pt[MAX_POINTS]   = '0;
  assign lane_occ[MAX_POINTS]  = 1'b0;
  assign lane_drop[MAX_POINTS] = 1'b0;

  for (genvar j = 0; j < MAX_POINTS; j++) begin : g_lane
    pmpf_lane #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .load_en   (count_r == CNT_W'(j)),
      .self_drop (mrg.self_drop),
      .new_pt    (new_pt),
      .up_pt     (lane_pt[j+1]),
      .up_occ    (lane_occ[j+1]),
      .up_drop   (lane_drop[j+1]),
      .pt_o      (lane_pt[j]),
      .occ_o     (lane_occ[j]),
      .drop_o    (lane_drop[j]),
      .hit_o     (lane_hit[j])
    );
  end

  pmpf_merge #(
    .MAX_POINTS (MAX_POINTS)
  ) u_merge (
    .hit  (lane_hit),
    .occ  (lane_occ[MAX_POINTS-1:0]),
    .drop (lane_drop[MAX_POINTS-1:0]),
    .res  (mrg)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    out_strobe_nxt = 1'b0;
    res_last       = 1'b0;
    res_none       = 1'b0;
    ctl.upd        = 1'b0;
    ctl.shift      = 1'b0;
    ctl.clear      = 1'b0;
    ctl.dim_mask   = dims_mask(dims_r);
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            ctl.upd   = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
          if (in_last_point) state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!mrg.any_kept) begin
          out_strobe_nxt = 1'b1;
          res_none       = 1'b1;
          res_last       = 1'b1;
          ctl.clear      = 1'b1;
          state_nxt      = ST_IDLE;
        end else if (mrg.head_last) begin
          out_strobe_nxt = 1'b1;
          res_last       = 1'b1;
          ctl.clear      = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          out_strobe_nxt = mrg.head_kept;
          ctl.shift      = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (ctl.clear) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      ovf_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      ovf_r        <= ovf_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // result word taken from the head lane
  always_ff @(posedge clk) begin
    if (out_strobe_nxt) begin
      for (int k = 0; k < NUM_COORDS; k++) begin
        out_pt_r[k] <= (!res_none && ctl.dim_mask[k]) ? lane_pt[0][k] : '0;
      end
      out_last_r <= res_last;
      out_none_r <= res_none;
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_coord_0    = out_pt_r[0];
  assign out_coord_1    = out_pt_r[1];
  assign out_coord_2    = out_pt_r[2];
  assign out_coord_3    = out_pt_r[3];
  assign out_last_kept  = out_last_r;
  assign out_none_kept  = out_none_r;
  assign out_overflowed = out_ovf_r;

  a_fall_with_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_strobe && out_last_kept))
    else $error("emission ended without a final word");

  a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("word produced outside emission");

  a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_none_kept) |-> (out_last_kept && (out_coord_0 == '0)))
    else $error("empty-batch word malformed");

  a_last_starts_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_last_point) |=> busy)
    else $error("last point did not start emission");

endmodule

[rtl/pmpf_lane.sv]
module pmpf_lane #(
  parameter int COORD_WIDTH = pmpf_pkg::COORD_WIDTH_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  pmpf_pkg::lane_ctl_t                                 ctl,
  input  logic                                                load_en,
  input  logic                                                self_drop,
  input  logic [pmpf_pkg::NUM_COORDS-1:0][COORD_WIDTH-1:0]    new_pt,
  input  logic [pmpf_pkg::NUM_COORDS-1:0][COORD_WIDTH-1:0]    up_pt,
  input  logic                                                up_occ,
  input  logic                                                up_drop,
  output logic [pmpf_pkg::NUM_COORDS-1:0][COORD_WIDTH-1:0]    pt_o,
  output logic                                                occ_o,
  output logic                                                drop_o,
  output logic                                                hit_o
);
  import pmpf_pkg::*;

  logic [NUM_COORDS-1:0][COORD_WIDTH-1:0] pt_r;
  logic                                   occ_r;
  logic                                   drop_r;
  logic                                   new_covers;
  logic                                   old_covers;

  // componentwise compare in both directions over the active coordinates
  always_comb begin
    new_covers = 1'b1;
    old_covers = 1'b1;
    for (int k = 0; k < NUM_COORDS; k++) begin
      if (ctl.dim_mask[k] && (new_pt[k] < pt_r[k])) new_covers = 1'b0;
      if (ctl.dim_mask[k] && (pt_r[k] < new_pt[k])) old_covers = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r  <= 1'b0;
      drop_r <= 1'b0;
    end else if (ctl.clear) begin
      occ_r  <= 1'b0;
      drop_r <= 1'b0;
    end else if (ctl.shift) begin
      occ_r  <= up_occ;
      drop_r <= up_drop;
    end else if (ctl.upd) begin
      if (load_en) begin
        occ_r  <= 1'b1;
        drop_r <= self_drop;
      end else if (occ_r && old_covers) begin
        drop_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      pt_r <= up_pt;
    end else if (ctl.upd && load_en) begin
      pt_r <= new_pt;
    end
  end

  assign pt_o   = pt_r;
  assign occ_o  = occ_r;
  assign drop_o = drop_r;
  assign hit_o  = occ_r & new_covers;

endmodule

[rtl/pmpf_merge.sv]
module pmpf_merge #(
  parameter int MAX_POINTS = pmpf_pkg::MAX_POINTS_DEF
) (
  input  logic [MAX_POINTS-1:0] hit,
  input  logic [MAX_POINTS-1:0] occ,
  input  logic [MAX_POINTS-1:0] drop,
  output pmpf_pkg::merge_t      res
);
  import pmpf_pkg::*;

  logic [MAX_POINTS-1:0] kept;

  assign kept          = occ & ~drop;
  assign res.self_drop = |hit;
  assign res.any_kept  = |kept;
  assign res.head_kept = kept[0];
  assign res.head_last = kept[0] & ~(|kept[MAX_POINTS-1:1]);

endmodule

[sim/pareto_minimal_point_filter_tb.sv]
module pareto_minimal_point_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pmpf_pkg::*;

  localparam int MAXP = MAX_POINTS_DEF;
  localparam int CW   = COORD_WIDTH_DEF;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_POINTS = 30;

  typedef struct packed {
    logic [3:0][CW-1:0] c;
    logic               last;
  } point_t;

  typedef struct packed {
    logic [3:0][CW-1:0] c;
    logic               last_kept;
    logic               none_kept;
    logic               overflowed;
  } skyline_t;

  typedef struct packed {
    logic [CW-1:0] c0, c1, c2, c3;
    logic          last;
    logic          typed;
    logic [CW-1:0] e0, e1, e2, e3;
    logic          e_last;
    logic          e_none;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                psel, penable, pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                start;
  logic                busy;
  logic [CW-1:0]       in_coord_0, in_coord_1, in_coord_2, in_coord_3;
  logic                in_last_point;
  logic                out_strobe;
  logic [CW-1:0]       out_coord_0, out_coord_1, out_coord_2, out_coord_3;
  logic                out_last_kept, out_none_kept, out_overflowed;

  // predictor state
  logic [3:0][CW-1:0]  stored_pts [MAXP];
  bit                  dropped [MAXP];
  int unsigned         n_stored;
  bit                  overflow_hit;
  logic [DIMS_W-1:0]   dims_reg;

  skyline_t            batch_res [$];
  skyline_t            skyline_q [$];
  int unsigned         mismatches;
  bit                  start_hi;
  int unsigned         burst_left;
  skyline_t            want;

  dir_row_t dir_rows [19] = '{
    '{'hffff, 'hffff, 'hffff, 'hffff, 1, 1, 'hffff, 'hffff, 'hffff, 'hffff, 1, 0},
    '{0, 0, 0, 0, 1, 1, 0, 0, 0, 0, 1, 0},
    '{5, 5, 5, 5, 0, 0, 0, 0, 0, 0, 0, 0},
    '{5, 5, 5, 5, 1, 1, 0, 0, 0, 0, 1, 1},
    '{1, 2, 3, 4, 0, 0, 0, 0, 0, 0, 0, 0},
    '{4, 3, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0},
    '{2, 2, 2, 2, 1, 0, 0, 0, 0, 0, 0, 0},
    '{'haaaa, 'h5555, 'haaaa, 'h5555, 0, 0, 0, 0, 0, 0, 0, 0},
    '{'h5555, 'haaaa, 'h5555, 'haaaa, 1, 0, 0, 0, 0, 0, 0, 0},
    '{'hffff, 'hffff, 'hffff, 'hffff, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 1, 1, 1, 0, 0, 0, 0, 1, 0},
    '{7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 7, 1, 0, 0, 0, 0, 0, 0, 0},
    '{3, 3, 3, 3, 0, 0, 0, 0, 0, 0, 0, 0},
    '{3, 3, 3, 3, 0, 0, 0, 0, 0, 0, 0, 0},
    '{1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0}
  };

  logic [DIMS_W-1:0] dims_plan [NUM_PHASES] = '{
    3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd7, 3'd5, 3'd6, 3'd2, 3'd1
  };

  pareto_minimal_point_filter i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit covers(input logic [3:0][CW-1:0] a, input logic [3:0][CW-1:0] b,
                                input int unsigned d);
    for (int k = 0; k < d; k++)
      if (a[k] < b[k]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return CW'($urandom);
      1: return {CW{1'b1}} - CW'($urandom_range(0, 3));
      default: return CW'($urandom_range(0, 7));
    endcase
  endfunction

  task automatic clear_batch();
    n_stored = 0;
    overflow_hit = 1'b0;
    for (int j = 0; j < MAXP; j++) dropped[j] = 1'b0;
  endtask

  task automatic filter_point(input point_t p);
    int unsigned d;
    bit self_drop;
    bit any;
    int last_idx;
    skyline_t r;
    d = (dims_reg == 0) ? 1 : ((dims_reg > 4) ? 4 : dims_reg);
    batch_res.delete();
    if (n_stored < MAXP) begin
      self_drop = 1'b0;
      for (int j = 0; j < n_stored; j++) begin
        if (covers(p.c, stored_pts[j], d)) self_drop = 1'b1;
        if (covers(stored_pts[j], p.c, d)) dropped[j] = 1'b1;
      end
      stored_pts[n_stored] = p.c;
      dropped[n_stored] = self_drop;
      n_stored++;
    end else begin
      overflow_hit = 1'b1;
    end
    if (!p.last) return;
    any = 1'b0;
    last_idx = 0;
    for (int j = 0; j < n_stored; j++)
      if (!dropped[j]) begin
        any = 1'b1;
        last_idx = j;
      end
    if (!any) begin
      r = '0;
      r.last_kept = 1'b1;
      r.none_kept = 1'b1;
      r.overflowed = overflow_hit;
      batch_res.push_back(r);
    end else begin
      for (int j = 0; j < n_stored; j++) begin
        if (dropped[j]) continue;
        r = '0;
        for (int k = 0; k < d; k++) r.c[k] = stored_pts[j][k];
        r.last_kept = (j == last_idx);
        r.overflowed = overflow_hit;
        batch_res.push_back(r);
      end
    end
    clear_batch();
  endtask

  task automatic send_point(input point_t p, input bit typed = 1'b0,
                            input skyline_t typed_res = '0);
    start <= 1'b1;
    start_hi = 1'b1;
    in_coord_0 <= p.c[0];
    in_coord_1 <= p.c[1];
    in_coord_2 <= p.c[2];
    in_coord_3 <= p.c[3];
    in_last_point <= p.last;
    do @(posedge clk); while (busy !== 1'b0);
    filter_point(p);
    if (typed) skyline_q.push_back(typed_res);
    else foreach (batch_res[i]) skyline_q.push_back(batch_res[i]);
  endtask

  task automatic pace();
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      start <= 1'b0;
      start_hi = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
  endtask

  task automatic drain();
    if (start_hi) begin
      start <= 1'b0;
      start_hi = 1'b0;
    end
    while (skyline_q.size() != 0) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_dims(input logic [DIMS_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_DIMS_USED;
    pwdata <= DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    dims_reg = v;
  endtask

  task automatic check_field(input string name, input logic [CW-1:0] exp_v,
                             input logic [CW-1:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s expected %h got %h", $time, name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      if (skyline_q.size() == 0) begin
        $display("%0t: word with nothing expected, got %h %h %h %h last %b none %b ovf %b",
                 $time, out_coord_0, out_coord_1, out_coord_2, out_coord_3,
                 out_last_kept, out_none_kept, out_overflowed);
        mismatches++;
      end else begin
        want = skyline_q.pop_front();
        check_field("coord_0", want.c[0], out_coord_0);
        check_field("coord_1", want.c[1], out_coord_1);
        check_field("coord_2", want.c[2], out_coord_2);
        check_field("coord_3", want.c[3], out_coord_3);
        check_field("last_kept", CW'(want.last_kept), CW'(out_last_kept));
        check_field("none_kept", CW'(want.none_kept), CW'(out_none_kept));
        check_field("overflowed", CW'(want.overflowed), CW'(out_overflowed));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("pareto_minimal_point_filter_tb NOT OK");
    $finish;
  end

  initial begin
    point_t p;
    skyline_t w;
    dir_row_t r;
    int unsigned phase_points;
    int unsigned n;
    rst_n <= 1'b0;
    start <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= REG_DIMS_USED;
    pwdata <= '0;
    in_coord_0 <= '0;
    in_coord_1 <= '0;
    in_coord_2 <= '0;
    in_coord_3 <= '0;
    in_last_point <= 1'b0;
    mismatches = 0;
    start_hi = 1'b0;
    burst_left = 5;
    dims_reg = DIMS_RESET;
    clear_batch();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      p.c = {r.c3, r.c2, r.c1, r.c0};
      p.last = r.last;
      w.c = {r.e3, r.e2, r.e1, r.e0};
      w.last_kept = r.e_last;
      w.none_kept = r.e_none;
      w.overflowed = 1'b0;
      send_point(p, r.typed, w);
      pace();
    end
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_dims(dims_plan[ph]);
      phase_points = 0;
      while (phase_points < PHASE_POINTS) begin
        if (ph % 2 == 1 && phase_points == 0)
          n = (ph == 1) ? MAXP + 1 : $urandom_range(MAXP + 2, MAXP + 8);
        else
          n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          p.c = {rand_coord(), rand_coord(), rand_coord(), rand_coord()};
          p.last = (i == n - 1);
          send_point(p);
          pace();
        end
        phase_points += n;
      end
      drain();
    end

    repeat (MAXP + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("pareto_minimal_point_filter_tb OK");
    end else begin
      $display("pareto_minimal_point_filter_tb NOT OK");
    end
    $finish;
  end

endmodule
